/* design/staa_pkg.sv */
package staa_pkg;

  localparam int DataWidthDefault = 32;
  localparam int FieldWidth = 32;
  localparam int ModeWidth = 4;
  localparam int StatusWidth = 2;

  localparam logic [ModeWidth-1:0] OP_ADD = 4'd0;
  localparam logic [ModeWidth-1:0] OP_SUB = 4'd1;
  localparam logic [ModeWidth-1:0] OP_MUL = 4'd2;
  localparam logic [ModeWidth-1:0] OP_DIV = 4'd3;
  localparam logic [ModeWidth-1:0] OP_MOD = 4'd4;
  localparam logic [ModeWidth-1:0] OP_LT  = 4'd5;
  localparam logic [ModeWidth-1:0] OP_GT  = 4'd6;
  localparam logic [ModeWidth-1:0] OP_EQ  = 4'd7;
  localparam logic [ModeWidth-1:0] OP_AND = 4'd8;
  localparam logic [ModeWidth-1:0] OP_OR  = 4'd9;
  localparam logic [ModeWidth-1:0] OP_NEG = 4'd10;
  localparam logic [ModeWidth-1:0] OP_NOT = 4'd11;

  localparam logic [StatusWidth-1:0] ST_OK      = 2'd0;
  localparam logic [StatusWidth-1:0] ST_DIVZERO = 2'd1;
  localparam logic [StatusWidth-1:0] ST_INVALID = 2'd2;

  // control that rides with each item down the divider
  typedef struct packed {
    logic [ModeWidth-1:0]   mode;
    logic                   neg_q;
    logic                   neg_r;
    logic [StatusWidth-1:0] status;
  } staa_ctl_t;

endpackage

/* design/staa_divider.sv */
// pipelined restoring divider, one quotient bit per stage, with carried result
module staa_divider #(
  parameter int DataWidth = staa_pkg::DataWidthDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            in_valid,
  input  logic [DataWidth-1:0]            in_num,
  input  logic [DataWidth-1:0]            in_den,
  input  logic [DataWidth-1:0]            in_alt,
  input  staa_pkg::staa_ctl_t             in_ctl,
  output logic                            out_valid,
  output logic [DataWidth-1:0]            out_quo,
  output logic [DataWidth-1:0]            out_rem,
  output logic [DataWidth-1:0]            out_alt,
  output staa_pkg::staa_ctl_t             out_ctl
);
  import staa_pkg::*;

  localparam int Stages = DataWidth;

  logic [Stages:0]               vld;
  logic [DataWidth-1:0]          rem [Stages+1];
  logic [DataWidth-1:0]          quo [Stages+1];
  logic [DataWidth-1:0]          den [Stages+1];
  logic [DataWidth-1:0]          alt [Stages+1];
  staa_ctl_t                     ctl [Stages+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign quo[0] = in_num;
  assign den[0] = in_den;
  assign alt[0] = in_alt;
  assign ctl[0] = in_ctl;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [DataWidth:0]   trial;
    logic [DataWidth:0]   diff;
    logic                 fits;

    assign trial = {rem[s], quo[s][DataWidth-1]};
    assign diff  = trial - {1'b0, den[s]};
    assign fits  = ~diff[DataWidth];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (advance) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[s+1] <= fits ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
        quo[s+1] <= {quo[s][DataWidth-2:0], fits};
        den[s+1] <= den[s];
        alt[s+1] <= alt[s];
        ctl[s+1] <= ctl[s];
      end
    end
  end

  assign out_valid = vld[Stages];
  assign out_quo   = quo[Stages];
  assign out_rem   = rem[Stages];
  assign out_alt   = alt[Stages];
  assign out_ctl   = ctl[Stages];

endmodule

/* design/stack_top_integer_alu_core.sv */
// channel | handshake          | payload
// in      | in_valid/in_stall  | mode, left_operand, right_operand
// out     | out_valid/out_stall| result, status
// one item per cycle unless a finished item waits at a stalled output; the
// divider takes one quotient bit per stage. all ops go through the same pipe so
// order holds. rst clears the valid bits only. out_stall freezes the whole pipe
// only while out_valid is high; the input is stalled in exactly that case.
module stack_top_integer_alu_core #(
  parameter int DATA_WIDTH = staa_pkg::DataWidthDefault
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [staa_pkg::ModeWidth-1:0]        mode,
  input  logic signed [staa_pkg::FieldWidth-1:0] left_operand,
  input  logic signed [staa_pkg::FieldWidth-1:0] right_operand,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [staa_pkg::FieldWidth-1:0] result,
  output logic [staa_pkg::StatusWidth-1:0]      status
);
  import staa_pkg::*;

  localparam int W = DATA_WIDTH;

  logic advance;

  // stage 1: operand capture
  logic           s1_valid;
  logic [ModeWidth-1:0] s1_mode;
  logic [W-1:0]   s1_a, s1_b;

  // stage 2: simple ops, multiply, magnitudes
  logic           s2_valid;
  logic [W-1:0]   s2_ma, s2_mb, s2_alt;
  staa_ctl_t      s2_ctl;

  logic [W-1:0]   a_mag, b_mag, simple;
  logic [2*W-1:0] prod;
  staa_ctl_t      ctl_next;
  logic           a_neg, b_neg;

  logic           d_valid;
  logic [W-1:0]   d_quo, d_rem, d_alt;
  staa_ctl_t      d_ctl;

  logic           o_valid;
  logic [W-1:0]   o_result;
  logic [StatusWidth-1:0] o_status;
  logic [W-1:0]   fin;

  assign advance  = ~(o_valid & out_stall);
  assign in_stall = ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mode <= mode;
      s1_a    <= W'(left_operand);
      s1_b    <= W'(right_operand);
    end
  end

  assign a_neg = s1_a[W-1];
  assign b_neg = s1_b[W-1];
  assign a_mag = a_neg ? (W'(0) - s1_a) : s1_a;
  assign b_mag = b_neg ? (W'(0) - s1_b) : s1_b;
  assign prod  = s1_a * s1_b;

  always_comb begin
    simple = s1_a;
    ctl_next.mode   = s1_mode;
    ctl_next.neg_q  = a_neg ^ b_neg;
    ctl_next.neg_r  = a_neg;
    ctl_next.status = ST_OK;
    case (s1_mode)
      OP_ADD: simple = s1_a + s1_b;
      OP_SUB: simple = s1_a - s1_b;
      OP_MUL: simple = prod[W-1:0];
      OP_DIV, OP_MOD: begin
        if (s1_b == '0) ctl_next.status = ST_DIVZERO;
      end
      OP_LT:  simple = W'($signed(s1_a) < $signed(s1_b));
      OP_GT:  simple = W'($signed(s1_b) < $signed(s1_a));
      OP_EQ:  simple = W'(s1_a == s1_b);
      OP_AND: simple = W'((s1_a != '0) && (s1_b != '0));
      OP_OR:  simple = W'((s1_a != '0) || (s1_b != '0));
      OP_NEG: simple = W'(0) - s1_a;
      OP_NOT: simple = W'(s1_a == '0);
      default: ctl_next.status = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ma  <= a_mag;
      // zero divisor: feed 1 so the pipe stays harmless; status overrides
      s2_mb  <= (s1_b == '0) ? W'(1) : b_mag;
      s2_alt <= simple;
      s2_ctl <= ctl_next;
    end
  end

  staa_divider #(.DataWidth(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s2_valid),
    .in_num    (s2_ma),
    .in_den    (s2_mb),
    .in_alt    (s2_alt),
    .in_ctl    (s2_ctl),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_rem   (d_rem),
    .out_alt   (d_alt),
    .out_ctl   (d_ctl)
  );

  always_comb begin
    fin = d_alt;
    if (d_ctl.status == ST_OK) begin
      if (d_ctl.mode == OP_DIV) begin
        fin = d_ctl.neg_q ? (W'(0) - d_quo) : d_quo;
      end else if (d_ctl.mode == OP_MOD) begin
        fin = d_ctl.neg_r ? (W'(0) - d_rem) : d_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_result <= fin;
      o_status <= d_ctl.status;
    end
  end

  assign out_valid = o_valid;
  assign result    = FieldWidth'($signed(o_result));
  assign status    = o_status;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result) && $stable(status)))
    else $error("held item changed");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output stall");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_DIVZERO || status == ST_INVALID))
    else $error("bad status");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!out_stall && !d_valid) |=> !out_valid)
    else $error("item out of nowhere");

endmodule

/* dv/tb_stack_top_integer_alu_core.sv */
`timescale 1ns / 100ps

module tb_stack_top_integer_alu_core;
  import staa_pkg::*;

  localparam int W = DataWidthDefault;
  localparam int LATENCY = W + 3;
  localparam int N_RANDOM = 1880;

  typedef struct packed {
    logic [ModeWidth-1:0]   op;
    logic [FieldWidth-1:0]  a;
    logic [FieldWidth-1:0]  b;
    logic                   has_exp;
    logic [FieldWidth-1:0]  exp_val;
    logic [StatusWidth-1:0] exp_st;
  } row_t;

  typedef struct packed {
    logic [FieldWidth-1:0]  val;
    logic [StatusWidth-1:0] st;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ModeWidth-1:0] mode = '0;
  logic signed [FieldWidth-1:0] left_operand = '0;
  logic signed [FieldWidth-1:0] right_operand = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [FieldWidth-1:0] result;
  logic [StatusWidth-1:0] status;

  alu_res_t expected_q[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  int op_seen[16];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stack_top_integer_alu_core #(.DATA_WIDTH(W)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .left_operand(left_operand), .right_operand(right_operand),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .status(status)
  );

  function automatic alu_res_t alu_predict(logic [ModeWidth-1:0] op,
                                           logic signed [W-1:0] a,
                                           logic signed [W-1:0] b);
    alu_res_t r;
    logic [W-1:0] ma, mb, q, m;
    logic signed [W-1:0] v;
    v = a;
    r.st = ST_OK;
    ma = a[W-1] ? -a : a;
    mb = b[W-1] ? -b : b;
    case (op)
      OP_ADD: v = a + b;
      OP_SUB: v = a - b;
      OP_MUL: v = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          r.st = ST_DIVZERO;
        end else begin
          q = ma / mb;
          m = ma % mb;
          if (op == OP_DIV) v = (a[W-1] != b[W-1]) ? -q : q;
          else v = a[W-1] ? -m : m;
        end
      end
      OP_LT:  v = (a < b) ? 1 : 0;
      OP_GT:  v = (a > b) ? 1 : 0;
      OP_EQ:  v = (a == b) ? 1 : 0;
      OP_AND: v = (a != 0 && b != 0) ? 1 : 0;
      OP_OR:  v = (a != 0 || b != 0) ? 1 : 0;
      OP_NEG: v = -a;
      OP_NOT: v = (a == 0) ? 1 : 0;
      default: r.st = ST_INVALID;
    endcase
    r.val = FieldWidth'(v);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s at %0t: got %0h want %0h", what, $realtime, got, want);
    n_errors++;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'(int'($urandom_range(0, 8)) - 4);
      4: return 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  // sender: one item per accepted handshake, valid drops only across a gap
  task automatic send_item(logic [ModeWidth-1:0] op, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    left_operand <= a;
    right_operand <= b;
    expected_q.push_back(alu_predict(op, a, b));
    op_seen[op]++;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  row_t dir_rows[$];

  initial begin
    row_t rw;
    alu_res_t e;
    logic [ModeWidth-1:0] op;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // typed-in rows: extremes and error codes
    dir_rows.push_back({OP_ADD, 32'h7fff_ffff, 32'h1, 1'b1, 32'h8000_0000, ST_OK});
    dir_rows.push_back({OP_SUB, 32'h8000_0000, 32'h1, 1'b1, 32'h7fff_ffff, ST_OK});
    dir_rows.push_back({OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h8000_0000, ST_OK});
    dir_rows.push_back({OP_MOD, 32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h0, ST_OK});
    dir_rows.push_back({OP_DIV, 32'h1234_5678, 32'h0, 1'b1, 32'h1234_5678, ST_DIVZERO});
    dir_rows.push_back({OP_MOD, 32'h8000_0000, 32'h0, 1'b1, 32'h8000_0000, ST_DIVZERO});
    dir_rows.push_back({4'd12, 32'hdead_beef, 32'h5, 1'b1, 32'hdead_beef, ST_INVALID});
    dir_rows.push_back({4'd15, 32'hffff_ffff, 32'h0, 1'b1, 32'hffff_ffff, ST_INVALID});
    dir_rows.push_back({OP_NEG, 32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h8000_0000, ST_OK});
    dir_rows.push_back({OP_NOT, 32'h0, 32'hffff_ffff, 1'b1, 32'h1, ST_OK});
    // predictor-checked rows
    dir_rows.push_back({OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({OP_MUL, 32'h8000_0000, 32'hffff_ffff, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({OP_DIV, 32'hffff_fff9, 32'h2, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({OP_MOD, 32'hffff_fff9, 32'h2, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({OP_MOD, 32'h7, 32'hffff_fffe, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({OP_LT, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({OP_GT, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({OP_EQ, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({OP_AND, 32'h8000_0000, 32'h0, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({OP_OR, 32'h0, 32'h0, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({OP_NOT, 32'h8000_0000, 32'h0, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({4'd13, 32'h0, 32'h0, 1'b0, 32'h0, ST_OK});
    dir_rows.push_back({4'd14, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0, ST_OK});
    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      if (rw.has_exp) begin
        e = alu_predict(rw.op, rw.a, rw.b);
        if (e.val !== rw.exp_val || e.st !== rw.exp_st)
          report_mismatch("table row vs predictor", {e.val, 30'd0, e.st},
                          {rw.exp_val, 30'd0, rw.exp_st});
      end
      send_item(rw.op, rw.a, rw.b);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      // mostly valid codes, some invalid
      op = $urandom_range(0, 9) == 0 ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
      send_item(op, rand_operand(), rand_operand());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall, with one long hold-off early in the run and a stall-free window later
  initial begin
    int hold;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (n_sent >= 200 && n_sent < 210 && !hold_off) begin
        hold_off = 1'b1;
        out_stall <= 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        out_stall <= 1'b0;
      end else if (n_sent > 1000 && n_sent < 1200) begin
        out_stall <= 1'b0;
      end else begin
        hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 5);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    alu_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", {result, 30'd0, status}, '0);
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (result !== e.val) report_mismatch("result", {32'd0, result}, {32'd0, e.val});
        if (status !== e.st) report_mismatch("status", {62'd0, status}, {62'd0, e.st});
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    $display("sent %0d items over all %0d codes, checked %0d results", n_sent, 16, n_checked);
    $display("div/mod seen %0d/%0d, invalid codes %0d", op_seen[OP_DIV], op_seen[OP_MOD],
             op_seen[12] + op_seen[13] + op_seen[14] + op_seen[15]);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("simulation failed");
    $finish;
  end

endmodule
